// File: hdl/dlgrt_pkg.sv
// Shared types and constants of the delayed linear gain ramp table.
`default_nettype none
package dlgrt_pkg;

	localparam int DEF_NUM_STEMS = 8;
	localparam int MAX_RESULTS   = 8;
	localparam int CNT_W         = $clog2(MAX_RESULTS + 1);
	localparam int GAIN_W        = 17;
	localparam int LEN_W         = 24;
	localparam int EL_W          = 26;
	localparam int FPB_W         = 24;
	localparam int NOW_W         = 48;
	localparam int DT_W          = 20;
	localparam int TGT_W         = 18;
	localparam int STEM_W        = 3;
	localparam logic [GAIN_W-1:0] UNITY_GAIN = 17'd65536;
	localparam logic [FPB_W-1:0]  FPB_RESET  = 24'd22050;

	localparam logic CMD_SCHED = 1'b0;
	localparam logic CMD_TICK  = 1'b1;

	// one channel entry of the ramp table
	typedef struct packed {
		logic [GAIN_W-1:0]      cur;
		logic [GAIN_W-1:0]      start;
		logic [GAIN_W-1:0]      tgt;
		logic signed [EL_W-1:0] el;
		logic [LEN_W-1:0]       len;
	} ent_t;

	localparam int ENT_W = $bits(ent_t);

endpackage
`default_nettype wire

// File: hdl/dlgrt_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module dlgrt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule
`default_nettype wire

// File: hdl/dlgrt_div.sv
// Restoring divider, one quotient bit per cycle, 48-bit dividend by 24-bit divisor.
`default_nettype none
module dlgrt_div (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [47:0] num,
	input  wire logic [23:0] den,
	output logic             done,
	output logic [47:0]      quot,
	output logic [23:0]      rem
);
	logic [47:0] quo_q;
	logic [23:0] rem_q;
	logic [23:0] den_q;
	logic [5:0]  cnt_q;
	logic        done_q;
	logic [24:0] trial;
	logic        fit;

	assign trial = {rem_q, quo_q[47]};
	assign fit   = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q <= 6'd48;
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= num;
			rem_q <= '0;
			den_q <= den;
		end else if (cnt_q != '0) begin
			quo_q <= {quo_q[46:0], fit};
			rem_q <= fit ? 24'(trial - {1'b0, den_q}) : trial[23:0];
		end
	end

	assign done = done_q;
	assign quot = quo_q;
	assign rem  = rem_q;
endmodule
`default_nettype wire

// File: hdl/delayed_linear_gain_ramp_table_core.sv
// Top level of the delayed linear gain ramp table.
//
// channel   dir  data                                         marks
// s_*       in   tdata: stem, target, align, fade, now, tick  tuser: command
// m_*       out  tdata: out_stem, out_volume                  tlast: last
// cfg_*     in   frames_per_beat write                        none
//
// A schedule word passes the read, execute and write states, plus the divider state when beat
// alignment runs it. A tick walks the channels through read, execute and write, adding the emit
// state when a gain is emitted and multiply, sum and divider states when a ramp step needs them.
// Reset clears the table through per-entry valid bits; no clearing pass is needed.
// A stalled output holds the sequencer at its next result; input waits until the word is done.
`default_nettype none
module delayed_linear_gain_ramp_table_core #(
	parameter int NUM_STEMS = dlgrt_pkg::DEF_NUM_STEMS
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	input  wire logic [119:0] s_tdata,  // stem_index, target_volume, align_to_beat,
	                                    // fade_frames, now_frame, tick_frames, zero pad
	input  wire logic [0:0]   s_tuser,  // command
	output logic              m_tvalid,
	input  wire logic         m_tready,
	output logic [23:0]       m_tdata,  // out_stem, out_volume, zero pad
	output logic              m_tlast,
	input  wire logic         cfg_wen,
	input  wire logic [23:0]  cfg_wdata
);
	import dlgrt_pkg::*;

	localparam int CW = (NUM_STEMS > 1) ? $clog2(NUM_STEMS) : 1;

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_RD   = 4'd1;
	localparam logic [3:0] ST_EX   = 4'd2;
	localparam logic [3:0] ST_SDIV = 4'd3;
	localparam logic [3:0] ST_MUL  = 4'd4;
	localparam logic [3:0] ST_RSUM = 4'd5;
	localparam logic [3:0] ST_RDIV = 4'd6;
	localparam logic [3:0] ST_WR   = 4'd7;
	localparam logic [3:0] ST_EMIT = 4'd8;
	localparam logic [3:0] ST_FIN  = 4'd9;

	logic [3:0]             state_q;
	logic                   cmd_q;
	logic [STEM_W-1:0]      idx_q;
	logic [GAIN_W-1:0]      tgt_q;
	logic                   align_q;
	logic [LEN_W-1:0]       fade_q;
	logic [NOW_W-1:0]       now_q;
	logic [DT_W-1:0]        dt_q;
	logic [FPB_W-1:0]       fpb_q;
	logic [CW-1:0]          ch_q;
	ent_t                   w_q;
	logic                   emit_q;
	logic [CNT_W-1:0]       n_q;
	logic                   pend_valid_q;
	logic [STEM_W-1:0]      pend_stem_q;
	logic [GAIN_W-1:0]      pend_vol_q;
	logic [40:0]            prod_a_s1;
	logic [40:0]            prod_b_s1;
	logic                   m_tvalid_q;
	logic [23:0]            m_tdata_q;
	logic                   m_tlast_q;
	logic [NUM_STEMS-1:0]   valid_q;
	logic                   rd_valid_s1;

	logic                   s_acc;
	logic                   out_free;
	logic                   m_load;
	logic                   ram_we;
	logic                   ram_re;
	logic [CW-1:0]          ram_raddr;
	logic [CW-1:0]          ram_waddr;
	logic [ENT_W-1:0]       ram_rdata;
	ent_t                   ent;
	logic                   div_start;
	logic [47:0]            div_num;
	logic [23:0]            div_den;
	logic                   div_done;
	logic [47:0]            div_quot;
	logic [23:0]            div_rem;
	logic [6:0]             idx_ext;
	logic [6:0]             ch_ext;
	logic                   ch_last;
	logic signed [EL_W-1:0] dt_ext;
	logic signed [EL_W-1:0] e1;
	logic signed [EL_W-1:0] e0;
	logic signed [EL_W-1:0] e2;
	logic [FPB_W-1:0]       delay;
	logic signed [TGT_W-1:0] tv;
	logic [GAIN_W-1:0]      tv_clamped;
	logic [41:0]            ramp_num;

	assign s_tready = (state_q == ST_IDLE);
	assign s_acc    = s_tvalid && s_tready;
	assign out_free = !m_tvalid_q || m_tready;
	assign m_load   = out_free && pend_valid_q && (state_q == ST_EMIT || state_q == ST_FIN);
	assign idx_ext  = {4'b0, idx_q};
	assign ch_ext   = 7'(ch_q);
	assign ch_last  = (ch_q == CW'(NUM_STEMS - 1));
	assign ram_re   = (state_q == ST_RD);
	assign ram_raddr = (cmd_q == CMD_TICK) ? ch_q : idx_ext[CW-1:0];
	assign ram_waddr = ram_raddr;
	assign ram_we   = (state_q == ST_WR);
	assign ent      = rd_valid_s1 ? ent_t'(ram_rdata) : '0;

	// clamp requested gain into 0..unity
	assign tv = $signed(s_tdata[20:3]);
	always_comb begin
		if (tv < 0) begin
			tv_clamped = '0;
		end else if (tv > $signed({1'b0, UNITY_GAIN})) begin
			tv_clamped = UNITY_GAIN;
		end else begin
			tv_clamped = tv[GAIN_W-1:0];
		end
	end

	assign dt_ext = $signed({{(EL_W-DT_W){1'b0}}, dt_q});
	assign e1     = ent.el + dt_ext;
	assign e0     = (ent.el < 0) ? '0 : ent.el;
	assign e2     = e0 + dt_ext;
	assign delay  = (div_rem == '0) ? '0 : fpb_q - div_rem;
	assign ramp_num = {1'b0, prod_a_s1} + {1'b0, prod_b_s1} + 42'(w_q.len >> 1);

	assign div_start = (state_q == ST_EX && cmd_q == CMD_SCHED && align_q && fpb_q != '0)
	                || (state_q == ST_RSUM);
	assign div_num   = (cmd_q == CMD_SCHED) ? now_q : {6'b0, ramp_num};
	assign div_den   = (cmd_q == CMD_SCHED) ? fpb_q : w_q.len;

	dlgrt_ram #(
		.WIDTH (ENT_W),
		.DEPTH (NUM_STEMS),
		.AW    (CW)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (w_q),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	dlgrt_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.done   (div_done),
		.quot   (div_quot),
		.rem    (div_rem)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			fpb_q        <= FPB_RESET;
			valid_q      <= '0;
			rd_valid_s1  <= 1'b0;
			ch_q         <= '0;
			n_q          <= '0;
			emit_q       <= 1'b0;
			pend_valid_q <= 1'b0;
			m_tvalid_q   <= 1'b0;
		end else begin
			if (cfg_wen) begin
				fpb_q <= cfg_wdata;
			end
			if (m_tready && !m_load) begin
				m_tvalid_q <= 1'b0;
			end
			if (ram_re) begin
				rd_valid_s1 <= valid_q[ram_raddr];
			end
			if (ram_we) begin
				valid_q[ram_waddr] <= 1'b1;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (s_acc) begin
						ch_q <= '0;
						n_q  <= '0;
						if (s_tuser[0] == CMD_TICK || 32'(s_tdata[2:0]) < NUM_STEMS) begin
							state_q <= ST_RD;
						end
					end
				end
				ST_RD: begin
					state_q <= ST_EX;
				end
				ST_EX: begin
					if (cmd_q == CMD_SCHED) begin
						state_q <= (align_q && fpb_q != '0) ? ST_SDIV : ST_WR;
					end else if (ent.el < 0 && e1 < 0) begin
						emit_q  <= 1'b0;
						state_q <= ST_WR;
					end else if (ent.len == '0) begin
						emit_q  <= 1'b1;
						state_q <= ST_WR;
					end else if (ent.cur != ent.tgt) begin
						emit_q  <= 1'b1;
						state_q <= ($unsigned(e2) >= {2'b0, ent.len}) ? ST_WR : ST_MUL;
					end else begin
						emit_q  <= 1'b0;
						state_q <= ST_WR;
					end
				end
				ST_SDIV: begin
					if (div_done) begin
						state_q <= ST_WR;
					end
				end
				ST_MUL: begin
					state_q <= ST_RSUM;
				end
				ST_RSUM: begin
					state_q <= ST_RDIV;
				end
				ST_RDIV: begin
					if (div_done) begin
						state_q <= ST_WR;
					end
				end
				ST_WR: begin
					if (cmd_q == CMD_SCHED) begin
						state_q <= ST_IDLE;
					end else if (emit_q && n_q < CNT_W'(MAX_RESULTS)) begin
						state_q <= ST_EMIT;
					end else if (ch_last) begin
						state_q <= ST_FIN;
					end else begin
						ch_q    <= ch_q + CW'(1);
						state_q <= ST_RD;
					end
				end
				ST_EMIT: begin
					// hold the newest result back so the final one can carry tlast
					if (!pend_valid_q || out_free) begin
						if (pend_valid_q) begin
							m_tvalid_q <= 1'b1;
							m_tlast_q  <= 1'b0;
							m_tdata_q  <= {4'b0, pend_vol_q, pend_stem_q};
						end
						pend_valid_q <= 1'b1;
						pend_stem_q  <= ch_ext[2:0];
						pend_vol_q   <= w_q.cur;
						n_q          <= n_q + CNT_W'(1);
						if (ch_last) begin
							state_q <= ST_FIN;
						end else begin
							ch_q    <= ch_q + CW'(1);
							state_q <= ST_RD;
						end
					end
				end
				ST_FIN: begin
					if (!pend_valid_q) begin
						state_q <= ST_IDLE;
					end else if (out_free) begin
						m_tvalid_q   <= 1'b1;
						m_tlast_q    <= 1'b1;
						m_tdata_q    <= {4'b0, pend_vol_q, pend_stem_q};
						pend_valid_q <= 1'b0;
						state_q      <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (s_acc) begin
			cmd_q   <= s_tuser[0];
			idx_q   <= s_tdata[2:0];
			tgt_q   <= tv_clamped;
			align_q <= s_tdata[21];
			fade_q  <= s_tdata[45:22];
			now_q   <= s_tdata[93:46];
			dt_q    <= s_tdata[113:94];
		end
		if (state_q == ST_EX) begin
			if (cmd_q == CMD_SCHED) begin
				w_q.cur   <= ent.cur;
				w_q.start <= ent.cur;
				w_q.tgt   <= tgt_q;
				w_q.len   <= fade_q;
				w_q.el    <= '0;
			end else begin
				w_q <= ent;
				if (ent.el < 0 && e1 < 0) begin
					w_q.el <= e1;
				end else if (ent.len == '0) begin
					w_q.cur <= ent.tgt;
					w_q.el  <= e0;
				end else if (ent.cur != ent.tgt) begin
					w_q.el <= e2;
					if ($unsigned(e2) >= {2'b0, ent.len}) begin
						w_q.cur <= ent.tgt;
					end
				end else begin
					w_q.el <= e0;
				end
			end
		end
		if (state_q == ST_SDIV && div_done) begin
			w_q.el <= -$signed({2'b0, delay});
		end
		if (state_q == ST_MUL) begin
			prod_a_s1 <= w_q.start * (w_q.len - w_q.el[LEN_W-1:0]);
			prod_b_s1 <= w_q.tgt * w_q.el[LEN_W-1:0];
		end
		if (state_q == ST_RDIV && div_done) begin
			w_q.cur <= div_quot[GAIN_W-1:0];
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tlast  = m_tlast_q;

`ifndef SYNTHESIS
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		n_q <= CNT_W'(MAX_RESULTS))
		else $error("result count beyond limit");
	a_idle_flushed: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_IDLE |-> !pend_valid_q)
		else $error("held result left behind at end of tick");
	a_div_owner: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == ST_SDIV || state_q == ST_RDIV))
		else $error("divider finished with no waiting state");
	a_emit_slot: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT && pend_valid_q && !out_free) |=> state_q == ST_EMIT)
		else $error("result dropped while output stalled");
`endif
endmodule
`default_nettype wire

// File: dv/tb_delayed_linear_gain_ramp_table_core.sv
// Testbench for the delayed linear gain ramp table: directed and random streams checked against a predictor.
`timescale 1ns / 100ps
module tb_delayed_linear_gain_ramp_table_core;
	import dlgrt_pkg::*;

	localparam int LIMIT_CYCLES = 600000;
	localparam int SETTLE_CYCLES = 600;

	typedef struct packed {
		logic              cmd;
		logic [2:0]        stem;
		logic signed [17:0] tgt;
		logic              align;
		logic [23:0]       fade;
		logic [47:0]       now;
		logic [19:0]       dt;
	} word_t;

	typedef struct packed {
		logic [2:0]  stem;
		logic [16:0] vol;
		logic        last;
	} gain_upd_t;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [119:0] s_tdata = '0;
	logic [0:0]   s_tuser = '0;
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [23:0]  m_tdata;
	logic         m_tlast;
	logic         cfg_wen = 1'b0;
	logic [23:0]  cfg_wdata = '0;

	delayed_linear_gain_ramp_table_core u_top (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
		.cfg_wen(cfg_wen), .cfg_wdata(cfg_wdata)
	);

	always #1 clk = ~clk;

	// predictor copy of the ramp table
	logic [23:0] beat_len = FPB_RESET;
	logic [16:0] gain_cur [8];
	logic [16:0] gain_start [8];
	logic [16:0] gain_tgt [8];
	int          ramp_pos [8];
	logic [23:0] ramp_len [8];

	word_t     word_q [$];
	gain_upd_t gain_q [$];
	word_t     live;
	int        words_queued = 0;
	int        words_sent = 0;
	int        errors = 0;
	int        cycles = 0;
	int        burst_left = 0;
	int        gap_left = 0;
	int        stall_mode = 0;
	bit        hold_off = 0;

	task automatic report(input string msg);
		$display("ERROR: %s", msg);
		errors++;
	endtask

	task automatic apply_word(input word_t w);
		longint unsigned rem, num;
		int              dt, n;
		logic [16:0]     clamped;
		bit              emit;
		gain_upd_t       upd [$];
		gain_upd_t       u;
		if (w.cmd == CMD_SCHED) begin
			rem = 0;
			if (w.align && beat_len != 0) begin
				rem = longint'(w.now) % longint'(beat_len);
				if (rem != 0) rem = beat_len - rem;
			end
			if (w.tgt < 0) clamped = 0;
			else if (w.tgt > 65536) clamped = UNITY_GAIN;
			else clamped = w.tgt[16:0];
			gain_start[w.stem] = gain_cur[w.stem];
			gain_tgt[w.stem] = clamped;
			ramp_len[w.stem] = w.fade;
			ramp_pos[w.stem] = -int'(rem);
		end else begin
			dt = int'(w.dt);
			n = 0;
			for (int i = 0; i < 8; i++) begin
				emit = 0;
				if (ramp_pos[i] < 0) begin
					ramp_pos[i] += dt;
					if (ramp_pos[i] < 0) continue;
					ramp_pos[i] = 0;
				end
				if (ramp_len[i] == 0) begin
					gain_cur[i] = gain_tgt[i];
					emit = 1;
				end else if (gain_cur[i] != gain_tgt[i]) begin
					ramp_pos[i] += dt;
					if (ramp_pos[i] >= int'(ramp_len[i])) gain_cur[i] = gain_tgt[i];
					else begin
						num = longint'(gain_start[i]) * longint'(ramp_len[i] - ramp_pos[i])
							+ longint'(gain_tgt[i]) * longint'(ramp_pos[i])
							+ longint'(ramp_len[i] / 2);
						gain_cur[i] = 17'(num / longint'(ramp_len[i]));
					end
					emit = 1;
				end
				if (emit && n < MAX_RESULTS) begin
					u.stem = 3'(i);
					u.vol = gain_cur[i];
					u.last = 0;
					upd.push_back(u);
					n++;
				end
			end
			if (n > 0) upd[n-1].last = 1;
			foreach (upd[k]) gain_q.push_back(upd[k]);
		end
	endtask

	function automatic word_t sched_word(input logic [2:0] stem, input logic [17:0] tgt,
			input logic align, input logic [23:0] fade, input logic [47:0] now);
		word_t w;
		w = '0;
		w.cmd = CMD_SCHED; w.stem = stem; w.tgt = tgt; w.align = align;
		w.fade = fade; w.now = now;
		w.dt = 20'($urandom);
		return w;
	endfunction

	function automatic word_t tick_word(input logic [19:0] dt);
		word_t w;
		w = '0;
		w.cmd = CMD_TICK; w.dt = dt;
		w.stem = 3'($urandom); w.tgt = 18'($urandom); w.align = 1'($urandom);
		w.fade = 24'($urandom); w.now = {16'($urandom), 32'($urandom)};
		return w;
	endfunction

	function automatic word_t rand_word();
		logic [17:0] tgt;
		logic [23:0] fade;
		logic [19:0] dt;
		if ($urandom_range(0, 9) < 4) begin
			dt = ($urandom_range(0, 7) == 0) ? 20'($urandom) : 20'($urandom_range(0, 3000));
			return tick_word(dt);
		end
		tgt = ($urandom_range(0, 1) == 0) ? 18'($urandom_range(0, 65536)) : 18'($urandom);
		case ($urandom_range(0, 9))
			0: fade = 0;
			1: fade = 24'($urandom);
			default: fade = 24'($urandom_range(1, 5000));
		endcase
		return sched_word(3'($urandom), tgt, 1'($urandom),
			fade, {16'($urandom), 32'($urandom)});
	endfunction

	task automatic queue_word(input word_t w);
		word_q.push_back(w);
		words_queued++;
	endtask

	task automatic wait_idle();
		while (words_sent != words_queued || gain_q.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_beat_len(input logic [23:0] v);
		@(posedge clk);
		cfg_wen <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_wen <= 1'b0;
		beat_len = v;
	endtask

	// driver: bursts of words with random gaps
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				apply_word(live);
				words_sent++;
			end
			if (!(s_tvalid && !s_tready)) begin
				if (gap_left > 0 || word_q.size() == 0) begin
					if (gap_left > 0) gap_left--;
					s_tvalid <= 1'b0;
				end else begin
					live = word_q.pop_front();
					s_tvalid <= 1'b1;
					s_tuser <= live.cmd;
					s_tdata <= {6'd0, live.dt, live.now, live.fade, live.align, live.tgt,
						live.stem};
					if (burst_left > 0) burst_left--;
					else begin
						burst_left = $urandom_range(0, 12);
						gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
					end
				end
			end
		end
	end

	// long hold-off on the output, so the block fills and stalls its input
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == 3000) hold_off <= 1;
		if (cycles == 9000) hold_off <= 0;
		if (cycles > LIMIT_CYCLES) begin
			$display("delayed_linear_gain_ramp_table_core: mismatch");
			$finish;
		end
	end

	// monitor: compare each result word against the oldest expected gain update, and drive m_tready
	always @(posedge clk) begin
		gain_upd_t e;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				if (gain_q.size() == 0)
					report($sformatf("unexpected word stem=%0d vol=%0d", m_tdata[2:0],
						m_tdata[19:3]));
				else begin
					e = gain_q.pop_front();
					if (m_tdata[2:0] != e.stem || m_tdata[19:3] != e.vol || m_tlast != e.last)
						report($sformatf("got stem=%0d vol=%0d last=%0d want %0d %0d %0d",
							m_tdata[2:0], m_tdata[19:3], m_tlast, e.stem, e.vol, e.last));
				end
			end
			if (cycles % 97 == 0) stall_mode = $urandom_range(0, 2);
			case (stall_mode)
				0: m_tready <= !hold_off;
				1: m_tready <= !hold_off && $urandom_range(0, 1);
				default: m_tready <= !hold_off && (cycles % 4 == 0);
			endcase
		end
	end

	initial begin
		logic [23:0] beats [5];
		for (int i = 0; i < 8; i++) begin
			gain_cur[i] = 0; gain_start[i] = 0; gain_tgt[i] = 0;
			ramp_pos[i] = 0; ramp_len[i] = 0;
		end
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: clamp extremes, snap, long and short ramps, alignment cases, tick extremes
		queue_word(tick_word(20'd0));
		queue_word(sched_word(3'd0, 18'h1ffff, 1'b0, 24'd0, 48'd0));
		queue_word(sched_word(3'd1, 18'h20000, 1'b0, 24'd100, 48'd0));
		queue_word(sched_word(3'd2, 18'd65536, 1'b0, 24'd1000, 48'd0));
		queue_word(sched_word(3'd3, 18'd65537, 1'b1, 24'd500, 48'd44100));
		queue_word(sched_word(3'd4, 18'h3ffff, 1'b1, 24'hffffff, 48'hffffffffffff));
		queue_word(sched_word(3'd5, 18'd40000, 1'b1, 24'd300, 48'd1));
		queue_word(sched_word(3'd6, 18'd65536, 1'b0, 24'hffffff, 48'd7));
		queue_word(sched_word(3'd7, 18'd1, 1'b1, 24'd1, 48'd22049));
		queue_word(tick_word(20'd0));
		queue_word(tick_word(20'd1));
		queue_word(tick_word(20'd250));
		queue_word(tick_word(20'hfffff));
		queue_word(sched_word(3'd2, 18'd0, 1'b0, 24'd3, 48'd0));
		queue_word(tick_word(20'd1));
		queue_word(tick_word(20'd1));
		queue_word(tick_word(20'd1));
		queue_word(tick_word(20'd5000));
		queue_word(tick_word(20'hfffff));
		queue_word(tick_word(20'd30000));
		for (int i = 0; i < 10; i++) queue_word(rand_word());
		wait_idle();

		beats[0] = 24'd1; beats[1] = 24'd0; beats[2] = 24'hffffff;
		beats[3] = 24'($urandom_range(2, 3000)); beats[4] = FPB_RESET;
		for (int p = 0; p < 5; p++) begin
			write_beat_len(beats[p]);
			for (int i = 0; i < 25; i++) queue_word(rand_word());
			// a long delay is pending with the largest beat; let ticks run it out
			if (beats[p] == 24'hffffff)
				for (int i = 0; i < 18; i++) queue_word(tick_word(20'hfffff));
			wait_idle();
		end

		if (errors == 0)
			$display("delayed_linear_gain_ramp_table_core: match");
		else
			$display("delayed_linear_gain_ramp_table_core: mismatch");
		$finish;
	end

endmodule
